### hw/rtl/smae_pkg.sv
// Shared types, constants and helpers for the square matrix arithmetic engine.
package smae_pkg;

  localparam int unsigned MAX_ORDER = 8;
  localparam int unsigned CELLS     = MAX_ORDER * MAX_ORDER;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned IDX_W     = $clog2(MAX_ORDER);
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ACC_W     = VALUE_W + $clog2(MAX_ORDER);
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ADD_CONST = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_MAT   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCALE     = 2'd2;
  localparam logic [OP_W-1:0] OP_MUL_MAT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALAR = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              rd_en;
    logic              rd_first;
    logic              rd_last;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              elem_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_load;
  } dp_status_t;

  function automatic logic [SIZE_W-1:0] order_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = size;
    if (n == '0) n = SIZE_W'(1);
    if (n > SIZE_W'(MAX_ORDER)) n = SIZE_W'(MAX_ORDER);
    return n;
  endfunction

endpackage

### hw/rtl/square_matrix_arith_engine.sv
// Square matrix arithmetic engine: top level with configuration registers.
// Loads two n-by-n signed Q8.8 matrices as one element pair per beat (A in the low half
// of s_axis_tdata, B in the high half), row-major, at one beat per cycle. After the
// n*n-th beat the input stalls and the block emits the n*n signed Q16.16 results in
// row-major order, with row and column on each and tlast on the final one. Results
// are produced one at a time, the matrix product reading n element pairs for each and
// the elementwise operations one, set by the single read port of each element store
// feeding one shared multiply-accumulate path; output backpressure can stall them further.
// Loading of the next pair of matrices may begin while the final result still waits
// in the output register. Configuration writes are taken every cycle and must only be
// issued while no load or computation is in progress.
module square_matrix_arith_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [34:32] row, [37:35] col, [39:38] zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [smae_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smae_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [smae_pkg::SIZE_W-1:0]        size_q;
  logic [smae_pkg::OP_W-1:0]          op_q;
  logic signed [smae_pkg::ELEM_W-1:0] scalar_q;

  smae_pkg::ctrl_cmd_t  cmd;
  smae_pkg::dp_status_t status;

  logic signed [smae_pkg::VALUE_W-1:0] value;
  logic [smae_pkg::IDX_W-1:0]          row, col;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= smae_pkg::SIZE_W'(smae_pkg::MAX_ORDER);
      op_q     <= smae_pkg::OP_MUL_MAT;
      scalar_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        smae_pkg::CFG_SIZE:   size_q   <= cfg_data_i[smae_pkg::SIZE_W-1:0];
        smae_pkg::CFG_OP:     op_q     <= cfg_data_i[smae_pkg::OP_W-1:0];
        smae_pkg::CFG_SCALAR: scalar_q <= cfg_data_i[smae_pkg::ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  smae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_q),
    .op_i       (op_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  smae_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (op_q),
    .scalar_i    (scalar_q),
    .elem_a_i    (s_axis_tdata[15:0]),
    .elem_b_i    (s_axis_tdata[31:16]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (value),
    .row_o       (row),
    .col_o       (col),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, col, row, value};

endmodule

### hw/rtl/smae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/smae_ctrl.sv
// Controller: load counting and sequencing of store reads over the result matrix.
module smae_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [smae_pkg::SIZE_W-1:0]         size_i,
  input  logic [smae_pkg::OP_W-1:0]           op_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  smae_pkg::dp_status_t                status_i,
  output smae_pkg::ctrl_cmd_t                 cmd_o
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam int unsigned AW = smae_pkg::ADDR_W;
  localparam int unsigned IW = smae_pkg::IDX_W;
  localparam int unsigned CW = smae_pkg::CNT_W;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW-1:0] rowbase_q, rowbase_d, kbase_q, kbase_d;

  logic [smae_pkg::SIZE_W-1:0] n;
  logic [IW-1:0]               n_last;
  logic [AW-1:0]               n_step;
  logic [CW-1:0]               total;
  logic [CW-1:0]               cnt_inc;
  logic                        accept;
  logic                        is_mul;
  logic                        k_end;

  assign n       = smae_pkg::order_of(size_i);
  assign n_last  = IW'(n - smae_pkg::SIZE_W'(1));
  assign n_step  = AW'(n);
  assign total   = CW'(n) * CW'(n);
  assign cnt_inc = cnt_q + CW'(1);
  assign is_mul  = (op_i == smae_pkg::OP_MUL_MAT);
  assign k_end   = !is_mul || (k_q == n_last);

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.we        = accept && !cnt_q[CW-1];
    cmd_o.waddr     = cnt_q[AW-1:0];
    cmd_o.rd_en     = (state_q == ST_ISSUE);
    cmd_o.rd_first  = (k_q == '0);
    cmd_o.rd_last   = k_end;
    cmd_o.addr_a    = rowbase_q + AW'(is_mul ? k_q : j_q);
    cmd_o.addr_b    = is_mul ? (kbase_q + AW'(j_q)) : (rowbase_q + AW'(j_q));
    cmd_o.row       = i_q;
    cmd_o.col       = j_q;
    cmd_o.elem_last = (i_q == n_last) && (j_q == n_last);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    rowbase_d = rowbase_q;
    kbase_d   = kbase_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_inc >= total) begin
            cnt_d     = '0;
            state_d   = ST_ISSUE;
            i_d       = '0;
            j_d       = '0;
            k_d       = '0;
            rowbase_d = '0;
            kbase_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_ISSUE: begin
        if (k_end) begin
          k_d     = '0;
          kbase_d = '0;
          state_d = ST_WAIT;
        end else begin
          k_d     = k_q + IW'(1);
          kbase_d = kbase_q + n_step;
        end
      end
      ST_WAIT: begin
        if (status_i.res_load) begin
          if (j_q == n_last) begin
            j_d = '0;
            if (i_q == n_last) begin
              state_d = ST_LOAD;
            end else begin
              i_d       = i_q + IW'(1);
              rowbase_d = rowbase_q + n_step;
              state_d   = ST_ISSUE;
            end
          end else begin
            j_d     = j_q + IW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      rowbase_q <= '0;
      kbase_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      rowbase_q <= rowbase_d;
      kbase_q   <= kbase_d;
    end
  end

endmodule

### hw/rtl/smae_datapath.sv
// Datapath: element stores, shared multiply-accumulate, saturation and output register.
module smae_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smae_pkg::ctrl_cmd_t                 cmd_i,
  output smae_pkg::dp_status_t                status_o,
  input  logic [smae_pkg::OP_W-1:0]           op_i,
  input  logic signed [smae_pkg::ELEM_W-1:0]  scalar_i,
  input  logic [smae_pkg::ELEM_W-1:0]         elem_a_i,
  input  logic [smae_pkg::ELEM_W-1:0]         elem_b_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smae_pkg::VALUE_W-1:0] value_o,
  output logic [smae_pkg::IDX_W-1:0]          row_o,
  output logic [smae_pkg::IDX_W-1:0]          col_o,
  output logic                                last_o
);

  localparam int unsigned EW = smae_pkg::ELEM_W;
  localparam int unsigned VW = smae_pkg::VALUE_W;
  localparam int unsigned AW = smae_pkg::ACC_W;

  logic [EW-1:0] rdata_a, rdata_b;

  smae_ram #(.WIDTH(EW), .DEPTH(smae_pkg::CELLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (elem_a_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr_a),
    .rdata_o (rdata_a)
  );

  smae_ram #(.WIDTH(EW), .DEPTH(smae_pkg::CELLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (elem_b_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr_b),
    .rdata_o (rdata_b)
  );

  logic s1_v_q, s1_first_q, s1_last_q;
  logic s2_v_q, s2_first_q, s2_last_q;
  logic done_q;
  logic signed [VW-1:0] p_q, p_d;
  logic signed [AW-1:0] acc_q, acc_d;

  logic signed [EW-1:0]   a, b, mul_rhs, add_rhs;
  logic signed [VW-1:0]   prod;
  logic signed [EW:0]     sum;
  logic signed [VW-1:0]   sum_q16;
  logic                   res_load;
  logic signed [VW-1:0]   sat_val;

  logic                   out_v_q;
  logic signed [VW-1:0]   out_value_q;
  logic [smae_pkg::IDX_W-1:0] out_row_q, out_col_q;
  logic                   out_last_q;

  assign a       = rdata_a;
  assign b       = rdata_b;
  assign mul_rhs = (op_i == smae_pkg::OP_MUL_MAT) ? b : scalar_i;
  assign add_rhs = (op_i == smae_pkg::OP_ADD_MAT) ? b : scalar_i;
  assign prod    = a * mul_rhs;
  assign sum     = (EW+1)'(a) + (EW+1)'(add_rhs);
  assign sum_q16 = VW'(signed'({sum, 8'h00}));

  always_comb begin
    case (op_i)
      smae_pkg::OP_ADD_CONST, smae_pkg::OP_ADD_MAT: p_d = sum_q16;
      default:                                      p_d = prod;
    endcase
  end

  assign acc_d = s2_first_q ? AW'(p_q) : (acc_q + AW'(p_q));

  always_comb begin
    if (acc_q[AW-1:VW-1] == '0 || acc_q[AW-1:VW-1] == '1) begin
      sat_val = acc_q[VW-1:0];
    end else if (acc_q[AW-1]) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  assign res_load = done_q && (!out_v_q || out_ready_i);

  assign status_o.res_load = res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      done_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.rd_en;
      s2_v_q <= s1_v_q;
      if (s2_v_q && s2_last_q) begin
        done_q <= 1'b1;
      end else if (res_load) begin
        done_q <= 1'b0;
      end
      if (res_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.rd_first;
    s1_last_q  <= cmd_i.rd_last;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    if (s1_v_q) begin
      p_q <= p_d;
    end
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
    if (res_load) begin
      out_value_q <= sat_val;
      out_row_q   <= cmd_i.row;
      out_col_q   <= cmd_i.col;
      out_last_q  <= cmd_i.elem_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = out_value_q;
  assign row_o       = out_row_q;
  assign col_o       = out_col_q;
  assign last_o      = out_last_q;

endmodule

### hw/rtl/smae_checker.sv
// Port-level checker for the square matrix arithmetic engine, bound to the top level.
module smae_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == m_axis_tdata[37:35])
    else $error("final result not on the diagonal corner");

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken while results still pending");

  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("input resumed before final result was staged");

endmodule

bind square_matrix_arith_engine smae_checker u_smae_checker (.*);

### tb/sv/tb_square_matrix_arith_engine.sv
// Self-checking testbench for the square matrix arithmetic engine.
module tb_square_matrix_arith_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import smae_pkg::*;

  localparam int unsigned RAND_ITEMS   = 380;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned PLAN_ROWS    = 21;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               new_cfg;
    logic [SIZE_W-1:0]  size;
    logic [OP_W-1:0]    op;
    logic [ELEM_W-1:0]  scal;
    logic [ELEM_W-1:0]  a;
    logic [ELEM_W-1:0]  b;
    logic               fixed;
    logic [VALUE_W-1:0] val;
  } step_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [SIZE_W-1:0]        cfg_size   = SIZE_W'(8);
  logic [OP_W-1:0]          cfg_op     = OP_MUL_MAT;
  logic signed [ELEM_W-1:0] cfg_scalar = '0;
  logic signed [ELEM_W-1:0] mat_a [CELLS];
  logic signed [ELEM_W-1:0] mat_b [CELLS];
  int unsigned              pair_count = 0;
  result_t                  pending_results [$];

  int unsigned send_idle_pct = 29;
  int unsigned rcv_idle_pct  = 82;
  logic        hold_tgl      = 1'b0;
  int unsigned n_err         = 0;
  int unsigned n_rand        = 0;
  int unsigned n_cycles      = 0;

  step_row_t plan [PLAN_ROWS] = '{
    '{1'b1, 4'd1, OP_ADD_CONST, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, 32'h00FFFE00},
    '{1'b0, 4'd1, OP_ADD_CONST, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 32'hFFFFFF00},
    '{1'b1, 4'd1, OP_ADD_MAT,   16'h7FFF, 16'h8000, 16'h8000, 1'b1, 32'hFF000000},
    '{1'b0, 4'd1, OP_ADD_MAT,   16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 32'h00FFFE00},
    '{1'b1, 4'd1, OP_SCALE,     16'h8000, 16'h8000, 16'h1234, 1'b1, 32'h40000000},
    '{1'b0, 4'd1, OP_SCALE,     16'h8000, 16'h7FFF, 16'h0000, 1'b1, 32'hC0008000},
    '{1'b1, 4'd1, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h8000, 1'b1, 32'h40000000},
    '{1'b1, 4'd0, OP_MUL_MAT,   16'h0000, 16'h7FFF, 16'h8000, 1'b1, 32'hC0008000},
    '{1'b1, 4'd2, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h8000, 1'b0, 32'h00000000},
    '{1'b0, 4'd2, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h8000, 1'b0, 32'h00000000},
    '{1'b0, 4'd2, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h8000, 1'b0, 32'h00000000},
    '{1'b0, 4'd2, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h8000, 1'b1, 32'h7FFFFFFF},
    '{1'b1, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 32'h00000000},
    '{1'b0, 4'd3, OP_MUL_MAT,   16'h0000, 16'h8000, 16'h7FFF, 1'b1, 32'h80000000}
  };

  square_matrix_arith_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_order();
    if (cfg_size == '0) return 1;
    if (cfg_size > MAX_ORDER) return MAX_ORDER;
    return int'(cfg_size);
  endfunction

  function automatic void take_element_pair(input logic signed [ELEM_W-1:0] a,
                                            input logic signed [ELEM_W-1:0] b,
                                            input logic fixed,
                                            input logic [VALUE_W-1:0] fixed_val);
    int unsigned n;
    int unsigned p;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    longint      acc;
    result_t     r;
    n = eff_order();
    if (pair_count < CELLS) begin
      mat_a[pair_count] = a;
      mat_b[pair_count] = b;
    end
    pair_count = (pair_count + 1) % 128;
    if (pair_count < n * n) return;
    pair_count = 0;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        p = i * n + j;
        case (cfg_op)
          OP_ADD_CONST: acc = (longint'(mat_a[p]) + longint'(cfg_scalar)) * 256;
          OP_ADD_MAT:   acc = (longint'(mat_a[p]) + longint'(mat_b[p])) * 256;
          OP_SCALE:     acc = longint'(mat_a[p]) * longint'(cfg_scalar);
          OP_MUL_MAT: begin
            acc = 0;
            for (k = 0; k < n; k++)
              acc += longint'(mat_a[i * n + k]) * longint'(mat_b[k * n + j]);
          end
          default: acc = 0;
        endcase
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r.value = fixed ? fixed_val : VALUE_W'(acc);
        r.row   = IDX_W'(i);
        r.col   = IDX_W'(j);
        r.last  = (p + 1 == n * n);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic push_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic fixed, input logic [VALUE_W-1:0] fixed_val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    take_element_pair(a, b, fixed, fixed_val);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIZE:   cfg_size   = data[SIZE_W-1:0];
      CFG_OP:     cfg_op     = data[OP_W-1:0];
      CFG_SCALAR: cfg_scalar = data;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [SIZE_W-1:0] size, input logic [OP_W-1:0] op,
                           input logic [ELEM_W-1:0] scal);
    settle();
    write_reg(CFG_SIZE, {12'($urandom), size});
    write_reg(CFG_OP, {14'($urandom), op});
    write_reg(CFG_SCALAR, scal);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_matrices(input int unsigned mats);
    int unsigned cells;
    cells = mats * eff_order() * eff_order();
    repeat (cells) begin
      push_pair(rand_elem(), rand_elem(), 1'b0, '0);
      n_rand++;
    end
  endtask

  // receive side: check each beat, then choose the next ready
  initial begin : rx_side
    logic        hold_seen;
    int unsigned hold_left;
    result_t     exp_res;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: value %h row %0d col %0d",
                 m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[37:35]);
          n_err++;
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.value) begin
            $error("value: expected %h, got %h", exp_res.value, m_axis_tdata[31:0]);
            n_err++;
          end
          if (m_axis_tdata[34:32] !== exp_res.row) begin
            $error("row: expected %0d, got %0d", exp_res.row, m_axis_tdata[34:32]);
            n_err++;
          end
          if (m_axis_tdata[37:35] !== exp_res.col) begin
            $error("col: expected %0d, got %0d", exp_res.col, m_axis_tdata[37:35]);
            n_err++;
          end
          if (m_axis_tlast !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, m_axis_tlast);
            n_err++;
          end
        end
      end
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned       phase;
    int unsigned       mats;
    int unsigned       n;
    int unsigned       pick;
    logic [SIZE_W-1:0] size;
    logic [ELEM_W-1:0] scal;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one full product at the reset settings
    send_matrices(1);

    foreach (plan[r]) begin
      if (plan[r].new_cfg) apply_cfg(plan[r].size, plan[r].op, plan[r].scal);
      push_pair(plan[r].a, plan[r].b, plan[r].fixed, plan[r].val);
    end

    phase = 0;
    while (n_rand < RAND_ITEMS) begin
      if (n_rand < RAND_ITEMS / 3) begin
        send_idle_pct = 29;
        rcv_idle_pct  <= 82;
      end else if (n_rand < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 82;
        rcv_idle_pct  <= 29;
      end else begin
        send_idle_pct = 0;
        rcv_idle_pct  <= 0;
      end
      pick = $urandom_range(99);
      if (pick < 65) size = SIZE_W'($urandom_range(1, 4));
      else if (pick < 85) size = SIZE_W'($urandom_range(5, 7));
      else if (pick < 92) size = '0;
      else if (pick < 96) size = SIZE_W'(8);
      else size = SIZE_W'($urandom_range(9, 15));
      pick = $urandom_range(7);
      if (pick == 0) scal = 16'h8000;
      else if (pick == 1) scal = 16'h7FFF;
      else if (pick == 2) scal = 16'h0000;
      else scal = 16'($urandom);
      apply_cfg(size, OP_W'($urandom_range(3)), scal);
      n = eff_order();
      mats = $urandom_range(1, 48 / (n * n) + 1);
      if (phase % 4 == 1) begin
        hold_tgl <= ~hold_tgl;
        if (mats < 3) mats = 3;
      end
      send_matrices(mats);
      phase++;
    end

    settle();
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### square_matrix_arith_engine.f
hw/rtl/smae_pkg.sv
hw/rtl/smae_ram.sv
hw/rtl/smae_ctrl.sv
hw/rtl/smae_datapath.sv
hw/rtl/square_matrix_arith_engine.sv
hw/rtl/smae_checker.sv
tb/sv/tb_square_matrix_arith_engine.sv
